// ----- src/athd_pkg.sv -----
// Shared types, constants and fixed-point helpers for the audio-to-haptic unit.
// No dependencies; every other file imports this package.
package athd_pkg;

  localparam int QUIET_PACKETS_DEF = 100;
  localparam int QCNT_W  = 8;
  localparam int SMP_W   = 16;
  localparam int ST_W    = 24;
  localparam int MUL_W   = 27;
  localparam int PROD_W  = 54;
  localparam int DEN_W   = 32;
  localparam int QUO_W   = 34;
  localparam int RES_W   = 28;
  localparam int CFG_IW  = 8;
  localparam int CFG_DW  = 16;
  localparam int ONE_Q22 = 4194304;

  localparam logic [1:0] MODE_OFF      = 2'd0;
  localparam logic [1:0] MODE_FALLBACK = 2'd1;
  localparam logic [1:0] MODE_MIX      = 2'd2;
  localparam logic [1:0] MODE_REPLACE  = 2'd3;

  localparam logic OP_PROCESS = 1'b0;
  localparam logic OP_METER   = 1'b1;

  localparam logic [CFG_IW-1:0] REG_MODE      = 8'd0;
  localparam logic [CFG_IW-1:0] REG_LP_SELECT = 8'd1;
  localparam logic [CFG_IW-1:0] REG_GAIN      = 8'd2;
  localparam logic [CFG_IW-1:0] REG_PERCENT   = 8'd3;

  localparam logic [15:0] ATTACK_Q16  = 16'd26214;
  localparam logic [15:0] RELEASE_Q16 = 16'd1638;
  localparam logic [15:0] QUIET_LEVEL = 16'd256;
  localparam logic [DEN_W-1:0] GAIN_DIV = 32'd409600;

  typedef struct packed {
    logic                     start;
    logic signed [PROD_W-1:0] num;
    logic [DEN_W-1:0]         den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [QUO_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [15:0] lowpass_coef(input logic [1:0] sel);
    logic [15:0] c;
    case (sel)
      2'd0:    c = 16'd681;
      2'd1:    c = 16'd1359;
      2'd2:    c = 16'd2028;
      default: c = 16'd3357;
    endcase
    return c;
  endfunction

  // Arithmetic right shift by k that rounds to nearest, halves away from zero.
  function automatic logic signed [PROD_W-1:0] rnd_shr(input logic signed [PROD_W-1:0] v,
                                                       input int k);
    logic [PROD_W-1:0] m;
    logic [PROD_W-1:0] q;
    m = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    q = (m + (PROD_W'(1) << (k - 1))) >> k;
    return v[PROD_W-1] ? -$signed(q) : $signed(q);
  endfunction

  // Q2.22 to Q1.15 with rounding and saturation.
  function automatic logic signed [SMP_W-1:0] to_q15(input logic signed [RES_W-1:0] v);
    logic signed [PROD_W-1:0] r;
    logic signed [SMP_W-1:0]  o;
    r = rnd_shr(PROD_W'(v), 7);
    if (r > PROD_W'(32767)) begin
      o = 16'sh7FFF;
    end else if (r < PROD_W'(-32768)) begin
      o = 16'sh8000;
    end else begin
      o = r[SMP_W-1:0];
    end
    return o;
  endfunction

endpackage

// ----- src/athd_if.sv -----
// Channel interfaces of the audio-to-haptic unit: frame input, result output, config writes.
// Depends on athd_pkg.
interface athd_in_if;
  import athd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic signed [SMP_W-1:0] speaker_left;
  logic signed [SMP_W-1:0] speaker_right;
  logic signed [SMP_W-1:0] native_left;
  logic signed [SMP_W-1:0] native_right;
  logic                    packet_end;
  modport source(output valid, opcode, speaker_left, speaker_right, native_left,
                 native_right, packet_end, input ready);
  modport sink(input valid, opcode, speaker_left, speaker_right, native_left,
               native_right, packet_end, output ready);
endinterface

interface athd_out_if;
  import athd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] haptic_out_left;
  logic signed [SMP_W-1:0] haptic_out_right;
  logic [7:0]              speaker_meter;
  logic [7:0]              haptic_meter;
  modport source(output valid, haptic_out_left, haptic_out_right, speaker_meter,
                 haptic_meter, input ready);
  modport sink(input valid, haptic_out_left, haptic_out_right, speaker_meter,
               haptic_meter, output ready);
endinterface

interface athd_cfg_if;
  import athd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- src/audio_to_haptic_derivation_unit.sv -----
// Top level of the audio-to-haptic unit: sequencer, shared multiplier, state and meters.
// Depends on athd_pkg, the channel interfaces in athd_if and the divider athd_div.

// The unit takes one beat per frame and returns one beat per frame. A process beat
// scales the native haptic pair by haptic_gain and, unless the mode register is off, runs
// the speaker pair through a one-pole lowpass, an attack/release envelope, an
// envelope-weighted gain and an x/(1+|x|) soft clip, then picks native, synthetic or a
// soft-clipped mix per the mode register; the output is rounded to Q1.15 and clamped. A
// meter beat (opcode 1) returns both peak meters shifted right seven and decays each peak
// to 7/8. Frames are handled one at a time. A process beat with synthesis runs two
// divisions per channel on the bit-serial divider (three in mix mode), and each product
// of the shared multiplier passes through a wait state. A new frame is taken as soon as
// the previous one has been written to the output register, even if the consumer has
// not yet taken that result; a stalled output holds the next result in its final state.
// Configuration writes are always accepted and take effect at once; they should only be
// made while no frame is in flight.
module audio_to_haptic_derivation_unit #(
  parameter int QUIET_PACKETS = athd_pkg::QUIET_PACKETS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  athd_in_if.sink     in_ch,
  athd_out_if.source  out_ch,
  athd_cfg_if.sink    cfg_ch
);
  import athd_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_METER = 4'd1;
  localparam logic [3:0] S_GAIN  = 4'd2;
  localparam logic [3:0] S_NAT   = 4'd3;
  localparam logic [3:0] S_NATC  = 4'd4;
  localparam logic [3:0] S_LPC   = 4'd5;
  localparam logic [3:0] S_ENVC  = 4'd6;
  localparam logic [3:0] S_LPWC  = 4'd7;
  localparam logic [3:0] S_GDIV  = 4'd8;
  localparam logic [3:0] S_CLIP  = 4'd9;
  localparam logic [3:0] S_SEL   = 4'd10;
  localparam logic [3:0] S_MIXC  = 4'd11;
  localparam logic [3:0] S_OUTCH = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;
  localparam logic [3:0] S_MWAIT = 4'd14;
  localparam logic [3:0] S_DWAIT = 4'd15;

  localparam logic [QCNT_W-1:0] QCNT_MAX = QCNT_W'(2 * QUIET_PACKETS);
  localparam logic [QCNT_W-1:0] QCNT_ON  = QCNT_W'(QUIET_PACKETS);

  // Control state.
  logic [3:0]        state_r;
  logic [3:0]        ret_r;
  logic              ch_r;
  logic              pend_r;
  logic              out_valid_r;

  // Configuration registers.
  logic [1:0]        mode_r;
  logic [1:0]        lps_r;
  logic [15:0]       hg_r;
  logic [8:0]        pct_r;

  // Filter, envelope, quiet counter and meters.
  logic signed [ST_W-1:0] lp_r  [2];
  logic signed [ST_W-1:0] env_r [2];
  logic [QCNT_W-1:0]      qcnt_r;
  logic [15:0]            spk_pk_r;
  logic [15:0]            hap_pk_r;

  // Frame payload and datapath registers.
  logic signed [SMP_W-1:0]  spk_r [2];
  logic signed [SMP_W-1:0]  nat_r [2];
  logic signed [MUL_W-1:0]  gain_r;
  logic signed [MUL_W-1:0]  mul_a_r;
  logic signed [MUL_W-1:0]  mul_b_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [RES_W-1:0]  h_r;
  logic signed [RES_W-1:0]  res_r;
  logic signed [SMP_W-1:0]  ql_r;
  logic signed [SMP_W-1:0]  qr_r;

  // Output register.
  logic signed [SMP_W-1:0] out_l_r;
  logic signed [SMP_W-1:0] out_rt_r;
  logic [7:0]              spk_m_r;
  logic [7:0]              hap_m_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                     in_fire;
  logic                     out_free;
  logic                     fallback;
  logic [15:0]              abs_sl, abs_sr, abs_nl, abs_nr;
  logic [15:0]              spk_pk_nxt, hap_pk_nxt;
  logic signed [22:0]       x_cur;
  logic signed [ST_W:0]     lp_diff;
  logic signed [ST_W-1:0]   lp_new;
  logic [ST_W-1:0]          a_mag;
  logic signed [ST_W:0]     env_diff;
  logic                     attack;
  logic signed [ST_W-1:0]   env_new;
  logic signed [MUL_W-1:0]  w_cur;
  logic signed [MUL_W-1:0]  lpw;
  logic signed [PROD_W-1:0] clip_src;
  logic [PROD_W-1:0]        clip_mag;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign fallback     = qcnt_r >= QCNT_ON;

  assign out_ch.valid            = out_valid_r;
  assign out_ch.haptic_out_left  = out_l_r;
  assign out_ch.haptic_out_right = out_rt_r;
  assign out_ch.speaker_meter    = spk_m_r;
  assign out_ch.haptic_meter     = hap_m_r;

  // Peak tracking on the incoming beat; the most negative sample counts as 32768.
  assign abs_sl = in_ch.speaker_left[SMP_W-1]  ? 16'(-in_ch.speaker_left)  : 16'(in_ch.speaker_left);
  assign abs_sr = in_ch.speaker_right[SMP_W-1] ? 16'(-in_ch.speaker_right) : 16'(in_ch.speaker_right);
  assign abs_nl = in_ch.native_left[SMP_W-1]   ? 16'(-in_ch.native_left)   : 16'(in_ch.native_left);
  assign abs_nr = in_ch.native_right[SMP_W-1]  ? 16'(-in_ch.native_right)  : 16'(in_ch.native_right);

  always_comb begin
    spk_pk_nxt = spk_pk_r;
    if (abs_sl > spk_pk_nxt) spk_pk_nxt = abs_sl;
    if (abs_sr > spk_pk_nxt) spk_pk_nxt = abs_sr;
    hap_pk_nxt = hap_pk_r;
    if (abs_nl > hap_pk_nxt) hap_pk_nxt = abs_nl;
    if (abs_nr > hap_pk_nxt) hap_pk_nxt = abs_nr;
  end

  // Per-channel datapath. The speaker sample moves to Q2.22 by a shift of seven.
  assign x_cur    = $signed({spk_r[ch_r], 7'd0});
  assign lp_diff  = (ST_W+1)'(x_cur) - (ST_W+1)'(lp_r[ch_r]);
  assign lp_new   = lp_r[ch_r] + ST_W'(rnd_shr(prod_r, 16));
  assign a_mag    = lp_new[ST_W-1] ? ST_W'(-lp_new) : ST_W'(lp_new);
  assign env_diff = $signed({1'b0, a_mag}) - (ST_W+1)'(env_r[ch_r]);
  assign attack   = $signed({1'b0, a_mag}) > (ST_W+1)'(env_r[ch_r]);
  assign env_new  = env_r[ch_r] + ST_W'(rnd_shr(prod_r, 16));
  // Envelope weight 1 + 3 * env in Q2.22.
  assign w_cur    = MUL_W'(ONE_Q22) + (MUL_W'(env_new) <<< 1) + MUL_W'(env_new);
  assign lpw      = MUL_W'(rnd_shr(prod_r, 22));

  // Soft clip x / (1 + |x|): the mix state clips native plus synthetic, else the gain quotient.
  assign clip_src = (state_r == S_SEL) ? PROD_W'(h_r) + PROD_W'(div_rsp.quot)
                                       : PROD_W'(div_rsp.quot);
  assign clip_mag = clip_src[PROD_W-1] ? PROD_W'(-clip_src) : PROD_W'(clip_src);

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = clip_src <<< 22;
    div_req.den   = DEN_W'(ONE_Q22) + DEN_W'(clip_mag);
    unique case (state_r)
      S_GDIV: begin
        div_req.start = 1'b1;
        div_req.num   = prod_r;
        div_req.den   = GAIN_DIV;
      end
      S_CLIP: begin
        div_req.start = 1'b1;
      end
      S_SEL: begin
        div_req.start = (mode_r == MODE_MIX);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  athd_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // Shared multiplier: operands registered in one state, product registered in the next cycle.
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a_r) * PROD_W'(mul_b_r);
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_OFF;
      lps_r  <= 2'd0;
      hg_r   <= 16'd4096;
      pct_r  <= 9'd100;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        REG_MODE:      mode_r <= cfg_ch.data[1:0];
        REG_LP_SELECT: lps_r  <= cfg_ch.data[1:0];
        REG_GAIN:      hg_r   <= cfg_ch.data[15:0];
        REG_PERCENT:   pct_r  <= cfg_ch.data[8:0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
      lp_r[0]     <= '0;
      lp_r[1]     <= '0;
      env_r[0]    <= '0;
      env_r[1]    <= '0;
      qcnt_r      <= QCNT_MAX;
      spk_pk_r    <= '0;
      hap_pk_r    <= '0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            ch_r <= 1'b0;
            if (in_ch.opcode == OP_METER) begin
              state_r <= S_METER;
            end else begin
              spk_r[0] <= in_ch.speaker_left;
              spk_r[1] <= in_ch.speaker_right;
              nat_r[0] <= in_ch.native_left;
              nat_r[1] <= in_ch.native_right;
              pend_r   <= in_ch.packet_end;
              spk_pk_r <= spk_pk_nxt;
              hap_pk_r <= hap_pk_nxt;
              state_r  <= S_GAIN;
            end
          end
        end
        S_METER: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_l_r     <= '0;
            out_rt_r    <= '0;
            spk_m_r     <= spk_pk_r[14:7];
            hap_m_r     <= hap_pk_r[14:7];
            spk_pk_r    <= 16'((19'(spk_pk_r) * 19'd7) >> 3);
            hap_pk_r    <= 16'((19'(hap_pk_r) * 19'd7) >> 3);
            state_r     <= S_IDLE;
          end
        end
        S_GAIN: begin
          // Synthetic gain haptic_gain * percent, divided by 409600 later.
          mul_a_r <= MUL_W'($signed({1'b0, hg_r}));
          mul_b_r <= MUL_W'($signed({1'b0, pct_r}));
          ret_r   <= S_NAT;
          state_r <= S_MWAIT;
        end
        S_NAT: begin
          if (!ch_r) begin
            gain_r <= MUL_W'(prod_r);
          end
          mul_a_r <= MUL_W'(nat_r[ch_r]);
          mul_b_r <= MUL_W'($signed({1'b0, hg_r}));
          ret_r   <= S_NATC;
          state_r <= S_MWAIT;
        end
        S_NATC: begin
          // Native times Q4.12 gain is Q27; back to Q2.22.
          h_r <= RES_W'(rnd_shr(prod_r, 5));
          if (mode_r == MODE_OFF) begin
            res_r   <= RES_W'(rnd_shr(prod_r, 5));
            state_r <= S_OUTCH;
          end else begin
            mul_a_r <= MUL_W'($signed({1'b0, lowpass_coef(lps_r)}));
            mul_b_r <= MUL_W'(lp_diff);
            ret_r   <= S_LPC;
            state_r <= S_MWAIT;
          end
        end
        S_LPC: begin
          lp_r[ch_r] <= lp_new;
          mul_a_r    <= MUL_W'($signed({1'b0, attack ? ATTACK_Q16 : RELEASE_Q16}));
          mul_b_r    <= MUL_W'(env_diff);
          ret_r      <= S_ENVC;
          state_r    <= S_MWAIT;
        end
        S_ENVC: begin
          env_r[ch_r] <= env_new;
          mul_a_r     <= MUL_W'(lp_r[ch_r]);
          mul_b_r     <= w_cur;
          ret_r       <= S_LPWC;
          state_r     <= S_MWAIT;
        end
        S_LPWC: begin
          mul_a_r <= lpw;
          mul_b_r <= gain_r;
          ret_r   <= S_GDIV;
          state_r <= S_MWAIT;
        end
        S_GDIV: begin
          ret_r   <= S_CLIP;
          state_r <= S_DWAIT;
        end
        S_CLIP: begin
          ret_r   <= S_SEL;
          state_r <= S_DWAIT;
        end
        S_SEL: begin
          if (mode_r == MODE_REPLACE || (mode_r == MODE_FALLBACK && fallback)) begin
            res_r   <= RES_W'(div_rsp.quot);
            state_r <= S_OUTCH;
          end else if (mode_r == MODE_MIX) begin
            ret_r   <= S_MIXC;
            state_r <= S_DWAIT;
          end else begin
            res_r   <= h_r;
            state_r <= S_OUTCH;
          end
        end
        S_MIXC: begin
          res_r   <= RES_W'(div_rsp.quot);
          state_r <= S_OUTCH;
        end
        S_OUTCH: begin
          if (!ch_r) begin
            ql_r    <= to_q15(res_r);
            ch_r    <= 1'b1;
            state_r <= S_NAT;
          end else begin
            qr_r    <= to_q15(res_r);
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_l_r     <= ql_r;
            out_rt_r    <= qr_r;
            spk_m_r     <= '0;
            hap_m_r     <= '0;
            // The quiet counter sees the peak already updated by this frame.
            if (pend_r) begin
              if (hap_pk_r > QUIET_LEVEL) begin
                qcnt_r <= '0;
              end else if (qcnt_r < QCNT_MAX) begin
                qcnt_r <= qcnt_r + QCNT_W'(1);
              end
            end
            state_r <= S_IDLE;
          end
        end
        S_MWAIT: begin
          state_r <= ret_r;
        end
        S_DWAIT: begin
          if (div_rsp.done) begin
            state_r <= ret_r;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The quiet counter saturates at twice the fallback threshold.
  a_qcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= QCNT_MAX)
    else $error("quiet packet counter above its saturation value");

  // A division result only ever arrives while the sequencer waits for it.
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DWAIT)
    else $error("divider finished outside of a wait state");

  // The envelope follows a magnitude, so it never goes negative.
  a_env_sign: assert property (@(posedge clk) disable iff (!rst_n)
    !env_r[0][ST_W-1] && !env_r[1][ST_W-1])
    else $error("envelope state went negative");

endmodule

// ----- src/athd_div.sv -----
// Bit-serial restoring divider with round-to-nearest (halves away from zero).
// Depends on athd_pkg for the request and response structs.
module athd_div (
  input  logic               clk,
  input  logic               rst_n,
  input  athd_pkg::div_req_t req,
  output athd_pkg::div_rsp_t rsp
);
  import athd_pkg::*;

  localparam int CNT_W = $clog2(PROD_W + 1);

  logic                busy_r;
  logic                done_r;
  logic                neg_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [DEN_W-1:0]    rem_r;
  logic [DEN_W-1:0]    den_r;
  logic [PROD_W-1:0]   sh_r;
  logic [PROD_W-1:0]   mag;
  logic [PROD_W-1:0]   dividend;
  logic [DEN_W:0]      trial;
  logic                ge;
  logic [DEN_W-1:0]    rem_nxt;
  logic [QUO_W-1:0]    q;

  // Adding half the divisor to the magnitude gives rounded division.
  assign mag      = req.num[PROD_W-1] ? PROD_W'(-req.num) : PROD_W'(req.num);
  assign dividend = mag + PROD_W'(req.den >> 1);

  // One quotient bit per cycle: numerator bits leave the top, quotient bits enter below.
  assign trial   = {rem_r, sh_r[PROD_W-1]};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        sh_r   <= dividend;
        rem_r  <= '0;
        den_r  <= req.den;
        neg_r  <= req.num[PROD_W-1];
        cnt_r  <= CNT_W'(PROD_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        sh_r  <= {sh_r[PROD_W-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign q         = sh_r[QUO_W-1:0];
  assign rsp.done  = done_r;
  assign rsp.quot  = neg_r ? -$signed(q) : $signed(q);

endmodule

// ----- bench/athd_test_if.sv -----
`timescale 1ns / 1ps
// Bench-side note: the channel interfaces come from the RTL file src/athd_if.sv.
// This file only holds a small helper package for the bench; it depends on athd_pkg.
package athd_test_pkg;
  import athd_pkg::*;

  typedef struct packed {
    logic              opcode;
    logic signed [15:0] spk_l;
    logic signed [15:0] spk_r;
    logic signed [15:0] nat_l;
    logic signed [15:0] nat_r;
    logic              pkt_end;
  } frame_t;

  typedef struct packed {
    logic signed [15:0] hap_l;
    logic signed [15:0] hap_r;
    logic [7:0]         spk_meter;
    logic [7:0]         hap_meter;
  } haptic_res_t;
endpackage

// ----- bench/audio_to_haptic_derivation_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for audio_to_haptic_derivation_unit: directed and random frames,
// predicted by a fixed-point model kept here. Depends on athd_pkg, athd_if, athd_test_pkg.
module audio_to_haptic_derivation_unit_test;
  import athd_pkg::*;
  import athd_test_pkg::*;

  localparam longint CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  athd_in_if  in_ch();
  athd_out_if out_ch();
  athd_cfg_if cfg_ch();

  audio_to_haptic_derivation_unit uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // Mirror of the configuration registers and of the unit's running state.
  logic [1:0]  mode_q;
  logic [1:0]  lp_sel_q;
  logic [15:0] gain_q;
  logic [8:0]  pct_q;
  longint lp_l, lp_r, env_l, env_r;
  int unsigned quiet_cnt, spk_peak, hap_peak;

  haptic_res_t expected_q[$];
  int  errors = 0;
  bit  draining = 1'b0;
  longint cycles = 0;

  // Rounded division, halves away from zero; the denominator is positive.
  function automatic longint rdiv(longint num, longint den);
    longint m;
    longint q;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint absl(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint sclip(longint x);
    return rdiv(x * ONE_Q22, ONE_Q22 + absl(x));
  endfunction

  function automatic logic signed [15:0] sat_q15(longint v);
    longint r;
    r = rdiv(v, 128);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // One synthetic channel: lowpass, envelope, envelope-weighted gain and soft clip.
  task automatic synth(input longint s, inout longint lp, inout longint env,
                       input longint coeff, input longint g, output longint y);
    longint a;
    longint w;
    lp = lp + rdiv(coeff * (s * 128 - lp), 65536);
    a = absl(lp);
    if (a > env) env = env + rdiv(longint'(ATTACK_Q16) * (a - env), 65536);
    else         env = env + rdiv(longint'(RELEASE_Q16) * (a - env), 65536);
    w = ONE_Q22 + 3 * env;
    y = sclip(rdiv(rdiv(lp * w, ONE_Q22) * g, 409600));
  endtask

  task automatic predict_haptics(input frame_t f);
    haptic_res_t r;
    longint hl, hr, al, ar, coeff, g;
    bit fb;
    r = '0;
    if (f.opcode == OP_METER) begin
      r.spk_meter = 8'(spk_peak >> 7);
      r.hap_meter = 8'(hap_peak >> 7);
      spk_peak = spk_peak * 7 / 8;
      hap_peak = hap_peak * 7 / 8;
    end else begin
      if (absl(f.spk_l) > spk_peak) spk_peak = absl(f.spk_l);
      if (absl(f.spk_r) > spk_peak) spk_peak = absl(f.spk_r);
      if (absl(f.nat_l) > hap_peak) hap_peak = absl(f.nat_l);
      if (absl(f.nat_r) > hap_peak) hap_peak = absl(f.nat_r);
      fb = quiet_cnt >= QUIET_PACKETS_DEF;
      hl = rdiv(longint'(f.nat_l) * gain_q, 32);
      hr = rdiv(longint'(f.nat_r) * gain_q, 32);
      if (mode_q != MODE_OFF) begin
        case (lp_sel_q)
          2'd0: coeff = 681;
          2'd1: coeff = 1359;
          2'd2: coeff = 2028;
          default: coeff = 3357;
        endcase
        g = longint'(gain_q) * pct_q;
        synth(f.spk_l, lp_l, env_l, coeff, g, al);
        synth(f.spk_r, lp_r, env_r, coeff, g, ar);
        if (mode_q == MODE_REPLACE || (mode_q == MODE_FALLBACK && fb)) begin
          hl = al;
          hr = ar;
        end else if (mode_q == MODE_MIX) begin
          hl = sclip(hl + al);
          hr = sclip(hr + ar);
        end
      end
      if (f.pkt_end) begin
        if (hap_peak > QUIET_LEVEL) quiet_cnt = 0;
        else if (quiet_cnt < 2 * QUIET_PACKETS_DEF) quiet_cnt++;
      end
      r.hap_l = sat_q15(hl);
      r.hap_r = sat_q15(hr);
    end
    expected_q.push_back(r);
  endtask

  // Sends one frame after a random gap and records its expected result on acceptance.
  // Valid stays high after the beat; the next frame or the idle wait takes it down.
  task automatic send_frame(input frame_t f);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= f.opcode;
    in_ch.speaker_left <= f.spk_l;
    in_ch.speaker_right <= f.spk_r;
    in_ch.native_left <= f.nat_l;
    in_ch.native_right <= f.nat_r;
    in_ch.packet_end <= f.pkt_end;
    do @(posedge clk); while (!in_ch.ready);
    predict_haptics(f);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MODE:      mode_q = val[1:0];
      REG_LP_SELECT: lp_sel_q = val[1:0];
      REG_GAIN:      gain_q = val;
      REG_PERCENT:   pct_q = val[8:0];
      default: ;
    endcase
  endtask

  // Waits for every outstanding result, then lets the unit settle before a config write.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] m, input logic [1:0] s,
                           input logic [15:0] g, input logic [8:0] p);
    wait_idle();
    write_reg(REG_MODE, 16'(m));
    write_reg(REG_LP_SELECT, 16'(s));
    write_reg(REG_GAIN, g);
    write_reg(REG_PERCENT, 16'(p));
  endtask

  function automatic frame_t mk(logic op, int sl, int sr, int nl, int nr, logic pe);
    frame_t f;
    f.opcode = op;
    f.spk_l = 16'(sl);
    f.spk_r = 16'(sr);
    f.nat_l = 16'(nl);
    f.nat_r = 16'(nr);
    f.pkt_end = pe;
    return f;
  endfunction

  function automatic frame_t rand_frame(bit quiet_native);
    frame_t f;
    f = mk(OP_PROCESS, 0, 0, 0, 0, 1'b0);
    f.opcode = ($urandom_range(0, 15) == 0) ? OP_METER : OP_PROCESS;
    f.spk_l = 16'($urandom);
    f.spk_r = 16'($urandom);
    if (quiet_native) begin
      f.nat_l = 16'($urandom_range(0, 512) - 256);
      f.nat_r = 16'($urandom_range(0, 512) - 256);
    end else begin
      f.nat_l = 16'($urandom);
      f.nat_r = 16'($urandom);
    end
    f.pkt_end = ($urandom_range(0, 3) == 0);
    return f;
  endfunction

  // Directed extremes: full scale, most negative value, meter reads and full-scale meter.
  task automatic test_directed();
    send_frame(mk(OP_METER, 0, 0, 0, 0, 1'b0));
    send_frame(mk(OP_PROCESS, 32767, -32768, 32767, -32768, 1'b1));
    send_frame(mk(OP_METER, 1234, 1, 2, 3, 1'b1));
    send_frame(mk(OP_METER, 0, 0, 0, 0, 1'b0));
    configure(MODE_OFF, 2'd0, 16'hFFFF, 9'd0);
    send_frame(mk(OP_PROCESS, 0, 0, 32767, -32768, 1'b0));
    send_frame(mk(OP_PROCESS, -1, 1, -1, 1, 1'b0));
    configure(MODE_REPLACE, 2'd3, 16'hFFFF, 9'd511);
    repeat (4) send_frame(mk(OP_PROCESS, 32767, -32768, 0, 0, 1'b1));
    configure(MODE_MIX, 2'd1, 16'd4096, 9'd400);
    send_frame(mk(OP_PROCESS, -32768, 32767, 32767, -32768, 1'b0));
    send_frame(mk(OP_PROCESS, 100, -100, 0, 0, 1'b1));
    configure(MODE_FALLBACK, 2'd2, 16'd0, 9'd100);
    send_frame(mk(OP_PROCESS, 20000, -20000, 5000, 5000, 1'b1));
    send_frame(mk(OP_PROCESS, 20000, -20000, 0, 0, 1'b1));
    send_frame(mk(OP_METER, 0, 0, 0, 0, 1'b0));
  endtask

  // Fallback: meter reads decay the haptic peak below the quiet level, then quiet
  // packets build up until the synthetic path takes over.
  task automatic test_fallback();
    frame_t f;
    configure(MODE_FALLBACK, 2'($urandom), 16'd4096, 9'd100);
    repeat (40) send_frame(mk(OP_METER, 0, 0, 0, 0, 1'b0));
    repeat (130) begin
      f = rand_frame(1'b1);
      f.pkt_end = 1'b1;
      send_frame(f);
    end
    send_frame(mk(OP_PROCESS, 1000, 1000, 30000, 0, 1'b1));
    repeat (20) send_frame(rand_frame(1'b0));
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 12; ph++) begin
      configure(2'($urandom), 2'($urandom), 16'($urandom), 9'($urandom));
      repeat (125) send_frame(rand_frame($urandom_range(0, 1)));
    end
  endtask

  // Result checker with random stalls on the output side.
  initial begin
    int stall;
    haptic_res_t e;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = draining ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (expected_q.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_ch.haptic_out_left !== e.hap_l) begin
          $error("haptic_out_left exp %0d got %0d", e.hap_l, out_ch.haptic_out_left);
          errors++;
        end
        if (out_ch.haptic_out_right !== e.hap_r) begin
          $error("haptic_out_right exp %0d got %0d", e.hap_r, out_ch.haptic_out_right);
          errors++;
        end
        if (out_ch.speaker_meter !== e.spk_meter) begin
          $error("speaker_meter exp %0d got %0d", e.spk_meter, out_ch.speaker_meter);
          errors++;
        end
        if (out_ch.haptic_meter !== e.hap_meter) begin
          $error("haptic_meter exp %0d got %0d", e.hap_meter, out_ch.haptic_meter);
          errors++;
        end
      end
    end
  end

  // Watchdog on total cycles.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("audio_to_haptic_derivation_unit test failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.opcode <= OP_PROCESS;
    in_ch.speaker_left <= '0;
    in_ch.speaker_right <= '0;
    in_ch.native_left <= '0;
    in_ch.native_right <= '0;
    in_ch.packet_end <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_MODE;
    cfg_ch.data <= '0;
    mode_q = MODE_OFF;
    lp_sel_q = 2'd0;
    gain_q = 16'd4096;
    pct_q = 9'd100;
    lp_l = 0; lp_r = 0; env_l = 0; env_r = 0;
    quiet_cnt = 2 * QUIET_PACKETS_DEF;
    spk_peak = 0;
    hap_peak = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    // An index past the register list must be ignored.
    wait_idle();
    write_reg(8'd200, 16'hFFFF);
    test_fallback();
    test_random();
    in_ch.valid <= 1'b0;
    draining = 1'b1;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (errors == 0) begin
      $display("audio_to_haptic_derivation_unit test passed");
    end else begin
      $display("audio_to_haptic_derivation_unit test failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
src/athd_pkg.sv
src/athd_if.sv
src/athd_div.sv
src/audio_to_haptic_derivation_unit.sv
bench/athd_test_if.sv
bench/audio_to_haptic_derivation_unit_test.sv
